### src/bole_pkg.sv
// shared constants, codes and types for the bounded ordered list engine
`timescale 1ns / 1ps
`default_nettype none

package bole_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 3;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 7;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [CMD_W-1:0]             cmd_t;
  typedef logic [STATUS_W-1:0]          status_t;

  localparam cmd_t CMD_APPEND = 3'd0;
  localparam cmd_t CMD_INSERT = 3'd1;
  localparam cmd_t CMD_DELETE = 3'd2;
  localparam cmd_t CMD_SEARCH = 3'd3;
  localparam cmd_t CMD_READ   = 3'd4;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_BAD_POS   = 3'd4;

  localparam cnt_t CNT_FULL = cnt_t'(CAPACITY);

endpackage

`default_nettype wire

### src/bole_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/bounded_ordered_list_engine_unit.sv
// top level: list sequencer over one entry ram with a result register
//
//  channel | ports                                  | handshake
//  in      | in_command, in_value, in_position      | in_valid / in_stall
//  out     | out_status, out_found, out_data,       | out_valid / out_stall
//          | out_length                             |
//
// one command at a time; append and any error found at accept pass through S_OUT to the output register
// read passes S_RD_A, S_RD_C and S_OUT; search and delete scan each entry examined via S_SCAN_A and S_SCAN_C
// insert and delete move one entry per address state and write state, set by the single registered ram read port
// synchronous rst_n empties the list, ram contents are not cleared
// a stalled result waits in the output register while the next word is taken
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_list_engine_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bole_pkg::CMD_W-1:0]    in_command,
  input  wire logic signed [bole_pkg::DATA_WIDTH-1:0] in_value,
  input  wire logic [bole_pkg::POS_W-1:0]    in_position,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bole_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_found,
  output logic signed [bole_pkg::DATA_WIDTH-1:0] out_data,
  output logic [bole_pkg::LEN_W-1:0]         out_length
);
  import bole_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN_A = 4'd1;
  localparam logic [3:0] S_SCAN_C = 4'd2;
  localparam logic [3:0] S_DEL_A  = 4'd3;
  localparam logic [3:0] S_DEL_W  = 4'd4;
  localparam logic [3:0] S_INS_A  = 4'd5;
  localparam logic [3:0] S_INS_W  = 4'd6;
  localparam logic [3:0] S_RD_A   = 4'd7;
  localparam logic [3:0] S_RD_C   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_r, state_nxt;
  cmd_t       cmd_r, cmd_nxt;
  word_t      word_r, word_nxt;
  cnt_t       pos_r, pos_nxt;
  addr_t      idx_r, idx_nxt;
  cnt_t       count_r, count_nxt;
  status_t    res_status_r, res_status_nxt;
  logic       res_found_r, res_found_nxt;
  word_t      res_data_r, res_data_nxt;

  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r, out_status_nxt;
  logic       out_found_r, out_found_nxt;
  word_t      out_data_r, out_data_nxt;
  cnt_t       out_length_r, out_length_nxt;

  logic       mem_we;
  addr_t      mem_waddr;
  word_t      mem_wdata;
  addr_t      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  word_t      rd_word;

  cnt_t       in_pos_ext;
  cnt_t       idx_ext;
  cnt_t       idx_p1;
  cnt_t       pos_p1;

  assign rd_word    = word_t'(mem_rdata);
  assign in_pos_ext = cnt_t'(in_position);
  assign idx_ext    = cnt_t'(idx_r);
  assign idx_p1     = idx_ext + cnt_t'(1);
  assign pos_p1     = pos_r + cnt_t'(1);

  bole_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    word_nxt       = word_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_data_nxt   = res_data_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_data_nxt   = out_data_r;
    out_length_nxt = out_length_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = word_r;
    mem_raddr      = idx_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_command;
          word_nxt       = in_value;
          pos_nxt        = in_pos_ext;
          idx_nxt        = '0;
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          res_data_nxt   = '0;
          state_nxt      = S_OUT;
          unique case (in_command)
            CMD_APPEND: begin
              if (count_r == CNT_FULL) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[ADDR_W-1:0];
                mem_wdata = in_value;
                count_nxt = count_r + cnt_t'(1);
              end
            end
            CMD_INSERT: begin
              if (count_r == CNT_FULL) begin
                res_status_nxt = ST_FULL;
              end else if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else if (in_pos_ext >= count_r) begin
                res_status_nxt = ST_BAD_POS;
              end else begin
                idx_nxt   = count_r[ADDR_W-1:0];
                state_nxt = S_INS_A;
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN_A;
              end
            end
            CMD_SEARCH: begin
              if (count_r != '0) begin
                state_nxt = S_SCAN_A;
              end
            end
            CMD_READ: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else if (in_pos_ext >= count_r) begin
                res_status_nxt = ST_BAD_POS;
              end else begin
                state_nxt = S_RD_A;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_SCAN_A: begin
        mem_raddr = idx_r;
        state_nxt = S_SCAN_C;
      end
      S_SCAN_C: begin
        if (rd_word == word_r) begin
          if (cmd_r == CMD_SEARCH) begin
            res_found_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            state_nxt = S_DEL_A;
          end
        end else if (idx_p1 >= count_r) begin
          res_status_nxt = (cmd_r == CMD_DELETE) ? ST_NOT_FOUND : ST_OK;
          state_nxt      = S_OUT;
        end else begin
          idx_nxt   = idx_r + addr_t'(1);
          state_nxt = S_SCAN_A;
        end
      end
      S_DEL_A: begin
        if (idx_p1 < count_r) begin
          mem_raddr = idx_p1[ADDR_W-1:0];
          state_nxt = S_DEL_W;
        end else begin
          count_nxt = count_r - cnt_t'(1);
          state_nxt = S_OUT;
        end
      end
      S_DEL_W: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = rd_word;
        idx_nxt   = idx_r + addr_t'(1);
        state_nxt = S_DEL_A;
      end
      S_INS_A: begin
        if (idx_ext > pos_p1) begin
          mem_raddr = idx_r - addr_t'(1);
          state_nxt = S_INS_W;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pos_p1[ADDR_W-1:0];
          mem_wdata = word_r;
          count_nxt = count_r + cnt_t'(1);
          state_nxt = S_OUT;
        end
      end
      S_INS_W: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = rd_word;
        idx_nxt   = idx_r - addr_t'(1);
        state_nxt = S_INS_A;
      end
      S_RD_A: begin
        mem_raddr = pos_r[ADDR_W-1:0];
        state_nxt = S_RD_C;
      end
      S_RD_C: begin
        res_data_nxt = rd_word;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_data_nxt   = res_data_r;
          out_length_nxt = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    word_r       <= word_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_data_r   <= res_data_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_data_r   <= out_data_nxt;
    out_length_r <= out_length_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_data   = out_data_r;
  assign out_length = LEN_W'(out_length_r);

endmodule

`default_nettype wire

### src/bole_chk.sv
// port level checks for the list engine and their bind
`timescale 1ns / 1ps
`default_nettype none

module bole_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [bole_pkg::STATUS_W-1:0] out_status,
  input wire logic                          out_found,
  input wire logic signed [bole_pkg::DATA_WIDTH-1:0] out_data,
  input wire logic [bole_pkg::LEN_W-1:0]    out_length
);
  import bole_pkg::*;

  // an accepted word keeps the block busy in the cycle after the accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_length <= LEN_W'(CAPACITY)))
    else $error("length beyond capacity");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == ST_OK))
    else $error("found with error status");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_data == '0 && !out_found))
    else $error("data on failed word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data) && $stable(out_length)))
    else $error("stalled result changed");

endmodule

bind bounded_ordered_list_engine_unit bole_chk u_bole_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_status(out_status),
  .out_found (out_found),
  .out_data  (out_data),
  .out_length(out_length)
);

`default_nettype wire
